// ===== hdl/lbf_pkg.sv =====
package lbf_pkg;

    localparam int CH_N    = 3;
    localparam int COLOR_W = 8;
    localparam int STEP_W  = 9;
    localparam int ACC_W   = 17;
    localparam int DUR_W   = 15;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;
    localparam int JUMP_W  = 8;
    localparam int WORK_W  = 19;

    localparam logic [2:0] KIND_FADE     = 3'd0;
    localparam logic [2:0] KIND_REDIRECT = 3'd1;
    localparam logic [2:0] KIND_YANK     = 3'd2;
    localparam logic [2:0] KIND_SET      = 3'd3;
    localparam logic [2:0] KIND_ROTATE   = 3'd4;
    localparam logic [2:0] KIND_TICK     = 3'd5;
    localparam logic [2:0] KIND_READ     = 3'd6;
    localparam logic [2:0] KIND_NONE     = 3'd7;

    localparam logic CFG_LED_COUNT = 1'b0;
    localparam logic CFG_REPORT    = 1'b1;

    typedef logic [CH_N-1:0][COLOR_W-1:0] rgb_t;

    typedef struct packed {
        rgb_t                           color;
        rgb_t                           target;
        logic [CH_N-1:0][STEP_W-1:0]    step;
        logic [DUR_W-1:0]               dur;
        logic [CH_N-1:0][ACC_W-1:0]     acc;
    } led_word_t;

    localparam int WORD_W = $bits(led_word_t);

    typedef struct packed {
        logic [2:0]        kind;
        logic [IDX_W-1:0]  led;
        logic [DUR_W-1:0]  dur;
        rgb_t              rgb;
        logic [CNT_W-1:0]  cnt;
        logic [JUMP_W-1:0] jmp;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    typedef struct packed {
        logic [IDX_W-1:0] led_index;
        rgb_t             rgb;
        logic             last;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage

// ===== hdl/lbf_ram.sv =====
module lbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/lbf_fifo.sv =====
module lbf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hdl/lbf_front.sv =====
module lbf_front #(
    parameter int MAX_LEDS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [2:0]              kind,
    input  logic [5:0]              led,
    input  logic [14:0]             duration,
    input  logic [7:0]              red,
    input  logic [7:0]              green,
    input  logic [7:0]              blue,
    input  logic [6:0]              range_count,
    input  logic signed [7:0]       jump,
    input  logic                    cfg_write,
    input  logic                    cfg_index,
    input  logic [6:0]              cfg_data,
    output logic                    report,
    output logic                    cmd_push,
    output lbf_pkg::cmd_t           cmd_data,
    input  logic                    cmd_full
);
    import lbf_pkg::*;

    logic [CNT_W-1:0] led_count_reg;
    logic             report_reg;
    logic [CNT_W-1:0] active;
    logic [CNT_W-1:0] led_ext;
    logic [CNT_W:0]   range_end;
    logic [CNT_W-1:0] clip_cnt;
    logic             in_range;
    logic             keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= CNT_W'(64);
            report_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LED_COUNT: led_count_reg <= cfg_data;
                CFG_REPORT:    report_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign report    = report_reg;
    assign active    = (led_count_reg > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : led_count_reg;
    assign led_ext   = CNT_W'(led);
    assign in_range  = led_ext < active;
    assign range_end = (CNT_W+1)'(led_ext) + (CNT_W+1)'(range_count);
    assign clip_cnt  = (range_end > (CNT_W+1)'(active)) ? active - led_ext : range_count;

    // Classify: drop out-of-range, empty and unused commands here.
    always_comb
    begin
        cmd_data      = '0;
        cmd_data.kind = kind;
        cmd_data.led  = led;
        cmd_data.dur  = duration;
        cmd_data.rgb  = {blue, green, red};
        cmd_data.cnt  = range_count;
        cmd_data.jmp  = jump;
        keep          = 1'b0;
        unique case (kind)
            KIND_TICK:
            begin
                cmd_data.cnt = active;
                keep         = (active != '0);
            end
            KIND_ROTATE:
            begin
                cmd_data.cnt = clip_cnt;
                keep         = in_range && (clip_cnt != '0) && (jump != '0);
            end
            KIND_NONE:
            begin
                keep = 1'b0;
            end
            default:
            begin
                keep = in_range;
            end
        endcase
    end

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full && keep;

endmodule

// ===== hdl/lbf_back.sv =====
module lbf_back #(
    parameter int MAX_LEDS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              report,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    input  lbf_pkg::cmd_t     cmd_data,
    output logic              out_push,
    output lbf_pkg::result_t  out_data,
    input  logic              out_full
);
    import lbf_pkg::*;

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SREAD = 4'd1;
    localparam logic [3:0] S_SEXEC = 4'd2;
    localparam logic [3:0] S_TREAD = 4'd3;
    localparam logic [3:0] S_TLOAD = 4'd4;
    localparam logic [3:0] S_TITER = 4'd5;
    localparam logic [3:0] S_TWRT  = 4'd6;
    localparam logic [3:0] S_TEND  = 4'd7;
    localparam logic [3:0] S_RMOD  = 4'd8;
    localparam logic [3:0] S_CRD   = 4'd9;
    localparam logic [3:0] S_CWR   = 4'd10;
    localparam logic [3:0] S_RRD   = 4'd11;
    localparam logic [3:0] S_RWR   = 4'd12;

    logic [3:0]             state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       o_reg, o_next;
    logic [CNT_W-1:0]       dst_reg, dst_next;
    logic [JUMP_W-1:0]      r_reg, r_next;
    logic [MAX_LEDS-1:0]    valid_reg, valid_next;
    logic                   vld_q_reg, vld_q_next;
    logic                   pend_reg, pend_next;
    result_t                pend_item_reg, pend_item_next;
    led_word_t              word_reg, word_next;
    logic signed [CH_N-1:0][WORK_W-1:0] col_reg, col_next;
    logic signed [CH_N-1:0][WORK_W-1:0] a_reg, a_next;

    logic                   main_we, main_re, scr_we, scr_re;
    logic [AW-1:0]          main_waddr, main_raddr, scr_waddr, scr_raddr;
    led_word_t              main_wdata, main_rdata, scr_wdata, scr_rdata;
    led_word_t              rd_word, exec_word, tick_word;
    logic [CNT_W-1:0]       start_o, start_dst, idx_inc, o_inc, dst_inc;
    logic signed [WORK_W-1:0] span, tgt, col_c, a_c;
    logic                   busy;
    logic                   changed;

    lbf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LEDS)) u_main (
        .clk   (clk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .re    (main_re),
        .raddr (main_raddr),
        .rdata (main_rdata)
    );

    lbf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LEDS)) u_scratch (
        .clk   (clk),
        .we    (scr_we),
        .waddr (scr_waddr),
        .wdata (scr_wdata),
        .re    (scr_re),
        .raddr (scr_raddr),
        .rdata (scr_rdata)
    );

    // An entry never written since reset reads as all zero.
    assign rd_word   = vld_q_reg ? main_rdata : '0;
    assign start_o   = CNT_W'(cmd_reg.led) + o_reg;
    assign start_dst = CNT_W'(cmd_reg.led) + dst_reg;
    assign idx_inc   = idx_reg + 1'b1;
    assign o_inc     = o_reg + 1'b1;
    assign dst_inc   = (dst_reg + 1'b1 == cmd_reg.cnt) ? '0 : dst_reg + 1'b1;
    assign span      = WORK_W'(word_reg.dur);

    // Single-LED command edits.
    always_comb
    begin
        exec_word = rd_word;
        unique case (cmd_reg.kind)
            KIND_FADE:
            begin
                exec_word.dur    = (cmd_reg.dur == '0) ? DUR_W'(1) : cmd_reg.dur;
                exec_word.target = cmd_reg.rgb;
            end
            KIND_REDIRECT:
            begin
                exec_word.target = cmd_reg.rgb;
            end
            KIND_YANK:
            begin
                exec_word.color = cmd_reg.rgb;
            end
            default:
            begin
                exec_word.color  = cmd_reg.rgb;
                exec_word.target = cmd_reg.rgb;
                exec_word.dur    = '0;
            end
        endcase
        for (int c = 0; c < CH_N; c++)
        begin
            if (cmd_reg.kind == KIND_SET)
            begin
                exec_word.step[c] = '0;
            end
            else
            begin
                exec_word.step[c] = {1'b0, exec_word.target[c]} - {1'b0, exec_word.color[c]};
            end
        end
    end

    // Tick write-back word.
    always_comb
    begin
        tick_word = word_reg;
        for (int c = 0; c < CH_N; c++)
        begin
            tick_word.color[c] = col_reg[c][COLOR_W-1:0];
            tick_word.acc[c]   = report ? '0 : a_reg[c][ACC_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        o_next         = o_reg;
        dst_next       = dst_reg;
        r_next         = r_reg;
        valid_next     = valid_reg;
        vld_q_next     = vld_q_reg;
        pend_next      = pend_reg;
        pend_item_next = pend_item_reg;
        word_next      = word_reg;
        col_next       = col_reg;
        a_next         = a_reg;
        cmd_pop        = 1'b0;
        out_push       = 1'b0;
        out_data       = pend_item_reg;
        main_we        = 1'b0;
        main_waddr     = idx_reg[AW-1:0];
        main_wdata     = tick_word;
        main_re        = 1'b0;
        main_raddr     = idx_reg[AW-1:0];
        scr_we         = 1'b0;
        scr_waddr      = o_reg[AW-1:0];
        scr_wdata      = rd_word;
        scr_re         = 1'b0;
        scr_raddr      = o_reg[AW-1:0];
        busy           = 1'b0;
        changed        = 1'b0;
        tgt            = '0;
        col_c          = '0;
        a_c            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_data;
                    idx_next = '0;
                    o_next   = '0;
                    r_next   = cmd_data.jmp[JUMP_W-1] ? JUMP_W'(-cmd_data.jmp) : cmd_data.jmp;
                    unique case (cmd_data.kind)
                        KIND_TICK:   state_next = S_TREAD;
                        KIND_ROTATE: state_next = S_RMOD;
                        default:     state_next = S_SREAD;
                    endcase
                end
            end
            S_SREAD:
            begin
                main_re    = 1'b1;
                main_raddr = cmd_reg.led[AW-1:0];
                vld_q_next = valid_reg[cmd_reg.led[AW-1:0]];
                state_next = S_SEXEC;
            end
            S_SEXEC:
            begin
                if (cmd_reg.kind == KIND_READ)
                begin
                    out_data.led_index = cmd_reg.led;
                    out_data.rgb       = rd_word.color;
                    out_data.last      = 1'b1;
                    if (!out_full)
                    begin
                        out_push   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    main_we    = 1'b1;
                    main_waddr = cmd_reg.led[AW-1:0];
                    main_wdata = exec_word;
                    valid_next[cmd_reg.led[AW-1:0]] = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TREAD:
            begin
                main_re    = 1'b1;
                vld_q_next = valid_reg[idx_reg[AW-1:0]];
                state_next = S_TLOAD;
            end
            S_TLOAD:
            begin
                word_next = rd_word;
                for (int c = 0; c < CH_N; c++)
                begin
                    col_next[c] = WORK_W'(rd_word.color[c]);
                    a_next[c]   = WORK_W'($signed(rd_word.acc[c]));
                    if (rd_word.color[c] != rd_word.target[c])
                    begin
                        changed   = 1'b1;
                        a_next[c] = WORK_W'($signed(rd_word.acc[c]))
                                  + WORK_W'($signed(rd_word.step[c]));
                    end
                end
                if (rd_word.dur != '0 && changed)
                begin
                    state_next = S_TITER;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == cmd_reg.cnt) ? S_TEND : S_TREAD;
                end
            end
            S_TITER:
            begin
                // One correction per channel per cycle.
                for (int c = 0; c < CH_N; c++)
                begin
                    tgt   = WORK_W'(word_reg.target[c]);
                    col_c = col_reg[c];
                    a_c   = a_reg[c];
                    if (col_c != tgt && a_c < 0)
                    begin
                        a_next[c]   = a_c + span;
                        col_next[c] = col_c - 1'b1;
                        busy        = 1'b1;
                    end
                    else if (col_c != tgt && a_c >= span)
                    begin
                        a_next[c]   = a_c - span;
                        col_next[c] = col_c + 1'b1;
                        busy        = 1'b1;
                    end
                end
                if (!busy)
                begin
                    state_next = S_TWRT;
                end
            end
            S_TWRT:
            begin
                if (!(pend_reg && out_full))
                begin
                    main_we                  = 1'b1;
                    valid_next[idx_reg[AW-1:0]] = 1'b1;
                    out_push                 = pend_reg;
                    pend_next                = 1'b1;
                    pend_item_next.led_index = IDX_W'(idx_reg);
                    pend_item_next.rgb       = tick_word.color;
                    pend_item_next.last      = 1'b0;
                    idx_next                 = idx_inc;
                    state_next               = (idx_inc == cmd_reg.cnt) ? S_TEND : S_TREAD;
                end
            end
            S_TEND:
            begin
                out_data.last = 1'b1;
                if (!pend_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_full)
                begin
                    out_push   = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_RMOD:
            begin
                if (r_reg >= JUMP_W'(cmd_reg.cnt))
                begin
                    r_next = r_reg - JUMP_W'(cmd_reg.cnt);
                end
                else if (r_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    dst_next   = cmd_reg.jmp[JUMP_W-1] ? cmd_reg.cnt - CNT_W'(r_reg)
                                                       : CNT_W'(r_reg);
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                main_re    = 1'b1;
                main_raddr = start_o[AW-1:0];
                vld_q_next = valid_reg[start_o[AW-1:0]];
                state_next = S_CWR;
            end
            S_CWR:
            begin
                scr_we = 1'b1;
                if (o_inc == cmd_reg.cnt)
                begin
                    o_next     = '0;
                    state_next = S_RRD;
                end
                else
                begin
                    o_next     = o_inc;
                    state_next = S_CRD;
                end
            end
            S_RRD:
            begin
                scr_re     = 1'b1;
                state_next = S_RWR;
            end
            S_RWR:
            begin
                main_we    = 1'b1;
                main_waddr = start_dst[AW-1:0];
                main_wdata = scr_rdata;
                valid_next[start_dst[AW-1:0]] = 1'b1;
                o_next     = o_inc;
                dst_next   = dst_inc;
                state_next = (o_inc == cmd_reg.cnt) ? S_IDLE : S_RRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
            o_reg     <= '0;
            dst_reg   <= '0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            vld_q_reg <= vld_q_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
            o_reg     <= o_next;
            dst_reg   <= dst_next;
            r_reg     <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pend_item_reg <= pend_item_next;
        word_reg      <= word_next;
        col_reg       <= col_next;
        a_reg         <= a_next;
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_push && out_full))
        else $error("result pushed into a full queue");

    a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TITER) |-> (word_reg.dur != '0))
        else $error("correction walk on a paused LED");

    a_tick_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEND && !out_full) |=> !pend_reg)
        else $error("pending result kept past end of tick");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("written-entry flag cleared");

endmodule

// ===== hdl/led_bresenham_fade_engine_top.sv =====
// Fade/redirect/yank/set/read: popped in IDLE, then SREAD and SEXEC; a read result then waits in the result queue.
// Tick: per active LED, TREAD then TLOAD when paused or unchanged, else also the TITER correction walk
//   of its three channels (one correction per channel per cycle in the shared walker) and TWRT.
// Rotate: RMOD takes |jump| modulo count by subtraction; per LED in range, CRD/CWR copy out, RRD/RWR copy back.
// Throughput: one command at a time in the executor; a 2-entry command queue absorbs bursts.
// Reset: rst_n asynchronous active low; all LED state reads as zero, led_count 64, no accumulator clear.
module led_bresenham_fade_engine_top #(
    parameter int MAX_LEDS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    // command side, queue-style
    input  logic              push,
    output logic              full,
    input  logic [2:0]        kind,
    input  logic [5:0]        led,
    input  logic [14:0]       duration,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    input  logic [6:0]        range_count,
    input  logic signed [7:0] jump,
    // result side, queue-style
    output logic              empty,
    input  logic              pop,
    output logic [5:0]        led_index,
    output logic [7:0]        out_red,
    output logic [7:0]        out_green,
    output logic [7:0]        out_blue,
    output logic              last,
    // configuration writes: index 0 led_count, index 1 report_resets_accumulator
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data
);
    import lbf_pkg::*;

    logic    report;
    logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t    cmd_in, cmd_out;
    logic    res_push, res_full;
    result_t res_in, res_out;

    // Front end: hold configuration, drop commands that do nothing, clip rotate ranges.
    lbf_front #(.MAX_LEDS(MAX_LEDS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .led         (led),
        .duration    (duration),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .range_count (range_count),
        .jump        (jump),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .report      (report),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_in),
        .cmd_full    (cmd_full)
    );

    // Short command queue: each side stalls on its own.
    lbf_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    // Back end: per-LED state in RAM, tick walker, rotate sequencer.
    lbf_back #(.MAX_LEDS(MAX_LEDS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .report    (report),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_out),
        .out_push  (res_push),
        .out_data  (res_in),
        .out_full  (res_full)
    );

    // Result queue: a finished transaction waits here while the back end moves on.
    lbf_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign led_index = res_out.led_index;
    assign out_red   = res_out.rgb[0];
    assign out_green = res_out.rgb[1];
    assign out_blue  = res_out.rgb[2];
    assign last      = res_out.last;

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lbf_pkg::*;

    // Sizes and time budgets. The settle wait is sized to cover one tick over
    // 64 LEDs with full correction walks.
    localparam int LEDS           = 64;
    localparam int SETTLE_CYCLES  = 20000;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int IDLE_PCT       = 22;
    localparam int REPORT_LIMIT   = 10;

    // One command transaction. The expected color is typed in only for
    // rows whose answer is obvious: reads after reset or right after a set.
    typedef struct {
        logic [2:0]        kind;
        logic [5:0]        led;
        logic [14:0]       dur;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        logic [6:0]        cnt;
        logic signed [7:0] jmp;
        bit                has_exp;
        logic [7:0]        er;
        logic [7:0]        eg;
        logic [7:0]        eb;
    } cmd_row_t;

    // One reported LED color.
    typedef struct {
        logic [5:0] idx;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } color_report_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [2:0]        kind;
    logic [5:0]        led;
    logic [14:0]       duration;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [6:0]        range_count;
    logic signed [7:0] jump;
    logic              empty;
    logic              pop;
    logic [5:0]        led_index;
    logic [7:0]        out_red;
    logic [7:0]        out_green;
    logic [7:0]        out_blue;
    logic              last;
    logic              cfg_write;
    logic              cfg_index;
    logic [6:0]        cfg_data;

    led_bresenham_fade_engine_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .led         (led),
        .duration    (duration),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .range_count (range_count),
        .jump        (jump),
        .empty       (empty),
        .pop         (pop),
        .led_index   (led_index),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .last        (last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Shadow copy of the per-LED state and of the two registers.
    logic [7:0] color_q  [LEDS][3];
    logic [7:0] target_q [LEDS][3];
    int         step_q   [LEDS][3];
    int         span_q   [LEDS];
    int         acc_q    [LEDS][3];
    int         active_count;
    bit         clear_on_report;

    color_report_t pending_colors[$];

    int  mismatch_cnt;
    int  stall_cycles;
    bit  steady;        // suppress idling on both sides while set

    // Free-running clock, 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Load the steps of one LED from its target and current color.
    function automatic void reload_steps(int i);
        for (int c = 0; c < 3; c++)
            step_q[i][c] = int'(target_q[i][c]) - int'(color_q[i][c]);
    endfunction

    // Queue up a report of the current color of LED i.
    function automatic void note_color(int i, logic fin);
        color_report_t rep;
        rep.idx  = i[5:0];
        rep.r    = color_q[i][0];
        rep.g    = color_q[i][1];
        rep.b    = color_q[i][2];
        rep.last = fin;
        pending_colors.push_back(rep);
    endfunction

    // Advance the shadow state by one accepted command and queue the colors
    // that the block should report for it.
    function automatic void fade_engine_predict(cmd_row_t c);
        logic [7:0] rgb_in [3];
        logic [7:0] t_col  [LEDS][3];
        logic [7:0] t_tgt  [LEDS][3];
        int         t_stp  [LEDS][3];
        int         t_spn  [LEDS];
        int         t_acc  [LEDS][3];
        int         cnt;
        int         jv;
        int         shift;
        int         li;
        int         first_rep;
        int         col;
        int         dst;
        int         a;
        int         d;
        bit         changed;

        rgb_in[0] = c.r;
        rgb_in[1] = c.g;
        rgb_in[2] = c.b;
        li = int'(c.led);

        if (c.kind == KIND_ROTATE)
        begin
            cnt = int'(c.cnt);
            jv  = int'(c.jmp);
            if (li >= active_count)
                return;
            if (li + cnt > active_count)
                cnt = active_count - li;
            if (cnt == 0)
                return;
            jv = jv % cnt;
            if (jv == 0)
                return;
            shift = (jv < 0) ? jv + cnt : jv;
            t_col = color_q;
            t_tgt = target_q;
            t_stp = step_q;
            t_spn = span_q;
            t_acc = acc_q;
            for (int o = 0; o < cnt; o++)
            begin
                d = li + (o + shift) % cnt;
                color_q[d]  = t_col[li + o];
                target_q[d] = t_tgt[li + o];
                step_q[d]   = t_stp[li + o];
                span_q[d]   = t_spn[li + o];
                acc_q[d]    = t_acc[li + o];
            end
            return;
        end

        if (c.kind == KIND_TICK)
        begin
            first_rep = pending_colors.size();
            for (int i = 0; i < active_count; i++)
            begin
                if (span_q[i] <= 0)
                    continue;
                changed = 1'b0;
                for (int ch = 0; ch < 3; ch++)
                begin
                    col = int'(color_q[i][ch]);
                    dst = int'(target_q[i][ch]);
                    if (col == dst)
                        continue;
                    a = acc_q[i][ch] + step_q[i][ch];
                    while (a < 0 && col != dst)
                    begin
                        a += span_q[i];
                        col--;
                    end
                    while (a >= span_q[i] && col != dst)
                    begin
                        a -= span_q[i];
                        col++;
                    end
                    acc_q[i][ch]   = a;
                    color_q[i][ch] = col[7:0];
                    changed = 1'b1;
                end
                if (changed)
                begin
                    if (clear_on_report)
                        for (int ch = 0; ch < 3; ch++)
                            acc_q[i][ch] = 0;
                    note_color(i, 1'b0);
                end
            end
            // Flag the final report of this tick, if any was made.
            if (pending_colors.size() > first_rep)
                pending_colors[pending_colors.size() - 1].last = 1'b1;
            return;
        end

        // Indexed commands: drop anything past the active range or unused kinds.
        if (c.kind == KIND_NONE || li >= active_count)
            return;

        case (c.kind)
            KIND_FADE:
            begin
                span_q[li] = (c.dur == 0) ? 1 : int'(c.dur);
                for (int ch = 0; ch < 3; ch++)
                    target_q[li][ch] = rgb_in[ch];
                reload_steps(li);
            end
            KIND_REDIRECT:
            begin
                for (int ch = 0; ch < 3; ch++)
                    target_q[li][ch] = rgb_in[ch];
                reload_steps(li);
            end
            KIND_YANK:
            begin
                for (int ch = 0; ch < 3; ch++)
                    color_q[li][ch] = rgb_in[ch];
                reload_steps(li);
            end
            KIND_SET:
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    color_q[li][ch]  = rgb_in[ch];
                    target_q[li][ch] = rgb_in[ch];
                    step_q[li][ch]   = 0;
                end
                span_q[li] = 0;
            end
            default:
                note_color(li, 1'b1);
        endcase
    endfunction

    // Drive one command and hold it until the block takes it. Push stays high
    // afterwards so back-to-back commands need no gap; the next call drops it
    // if it decides to idle.
    task automatic send_command(cmd_row_t c);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        kind        <= c.kind;
        led         <= c.led;
        duration    <= c.dur;
        red         <= c.r;
        green       <= c.g;
        blue        <= c.b;
        range_count <= c.cnt;
        jump        <= c.jmp;
        do
            @(posedge clk);
        while (full);
        fade_engine_predict(c);
        // Rows with a typed-in answer override the predicted color.
        if (c.has_exp && pending_colors.size() > 0)
        begin
            pending_colors[pending_colors.size() - 1].r = c.er;
            pending_colors[pending_colors.size() - 1].g = c.eg;
            pending_colors[pending_colors.size() - 1].b = c.eb;
        end
    endtask

    // Wait for every expected color, then let any silent tick or rotate finish.
    task automatic drain_engine();
        push <= 1'b0;
        @(posedge clk);
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register while the block is idle.
    task automatic write_register(logic idx, logic [6:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_LED_COUNT)
            active_count = (int'(value) > LEDS) ? LEDS : int'(value);
        else
            clear_on_report = value[0];
    endtask

    // Build a random command. Most are fades and ticks; the other kinds, the
    // unused one among them, fill the rest. Most aim at active LEDs with short
    // durations so fades actually land; the rest is noise: stray indexes, long durations.
    function automatic cmd_row_t random_command();
        cmd_row_t c;
        int       pick;
        int       dsel;
        pick = $urandom_range(99);
        if (pick < 28)
            c.kind = KIND_FADE;
        else if (pick < 56)
            c.kind = KIND_TICK;
        else if (pick < 66)
            c.kind = KIND_READ;
        else if (pick < 72)
            c.kind = KIND_REDIRECT;
        else if (pick < 78)
            c.kind = KIND_YANK;
        else if (pick < 84)
            c.kind = KIND_SET;
        else if (pick < 96)
            c.kind = KIND_ROTATE;
        else
            c.kind = KIND_NONE;
        if (active_count > 0 && $urandom_range(99) < 85)
            c.led = 6'($urandom_range(active_count - 1));
        else
            c.led = 6'($urandom_range(63));
        dsel = $urandom_range(99);
        if (dsel < 70)
            c.dur = 15'($urandom_range(6));
        else if (dsel < 95)
            c.dur = 15'($urandom_range(300, 7));
        else
            c.dur = 15'($urandom);
        c.r       = 8'($urandom);
        c.g       = 8'($urandom);
        c.b       = 8'($urandom);
        c.cnt     = 7'($urandom_range(64));
        c.jmp     = 8'($urandom_range(128) - 64);
        c.has_exp = 1'b0;
        c.er      = '0;
        c.eg      = '0;
        c.eb      = '0;
        return c;
    endfunction

    // Send n random commands; the no-idle stretch covers the middle third.
    task automatic random_phase(int n);
        for (int k = 0; k < n; k++)
        begin
            steady = (k >= n / 3 && k < 2 * n / 3);
            send_command(random_command());
        end
        steady = 1'b0;
    endtask

    // Result side: pop at random, check each popped color against the
    // oldest expectation.
    always @(posedge clk)
    begin
        color_report_t exp_rep;
        if (rst_n && pop && !empty)
        begin
            if (pending_colors.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("%0t: unexpected color led=%0d rgb=%02h%02h%02h last=%0b",
                             $time, led_index, out_red, out_green, out_blue, last);
            end
            else
            begin
                exp_rep = pending_colors.pop_front();
                if (led_index !== exp_rep.idx || out_red !== exp_rep.r ||
                    out_green !== exp_rep.g || out_blue !== exp_rep.b ||
                    last !== exp_rep.last)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display({"%0t: color mismatch exp led=%0d rgb=%02h%02h%02h last=%0b",
                                  " got led=%0d rgb=%02h%02h%02h last=%0b"},
                                 $time, exp_rep.idx, exp_rep.r, exp_rep.g, exp_rep.b,
                                 exp_rep.last, led_index, out_red, out_green, out_blue,
                                 last);
                end
            end
        end
        pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Directed rows: reset reads, extremes of every field, each command
    // kind, rotate clipping and zero-modulo cases, the unused kind.
    cmd_row_t directed_rows[] = '{
        '{KIND_READ,     6'd0,  15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd0,   1, 8'h00, 8'h00, 8'h00},
        '{KIND_READ,     6'd63, 15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd0,   1, 8'h00, 8'h00, 8'h00},
        '{KIND_TICK,     6'd0,  15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_SET,      6'd0,  15'd0,     8'hff, 8'h00, 8'h80, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_READ,     6'd0,  15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd0,   1, 8'hff, 8'h00, 8'h80},
        '{KIND_FADE,     6'd1,  15'd0,     8'hff, 8'hff, 8'hff, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_FADE,     6'd2,  15'd3,     8'h07, 8'h80, 8'h01, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_FADE,     6'd63, 15'h7fff,  8'hff, 8'h00, 8'hff, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_TICK,     6'd0,  15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_YANK,     6'd2,  15'd0,     8'hff, 8'h00, 8'h00, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_REDIRECT, 6'd1,  15'd0,     8'h00, 8'h40, 8'h00, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_TICK,     6'd0,  15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_ROTATE,   6'd0,  15'd0,     8'h00, 8'h00, 8'h00, 7'd64, 8'sd64,  0, 8'h00, 8'h00, 8'h00},
        '{KIND_ROTATE,   6'd0,  15'd0,     8'h00, 8'h00, 8'h00, 7'd3,  -8'sd1,  0, 8'h00, 8'h00, 8'h00},
        '{KIND_ROTATE,   6'd60, 15'd0,     8'h00, 8'h00, 8'h00, 7'd64, 8'sd5,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_ROTATE,   6'd0,  15'd0,     8'h00, 8'h00, 8'h00, 7'd64, -8'sd64, 0, 8'h00, 8'h00, 8'h00},
        '{KIND_ROTATE,   6'd5,  15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd7,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_NONE,     6'd63, 15'h7fff,  8'hff, 8'hff, 8'hff, 7'd127, -8'sd128, 0, 8'h00, 8'h00, 8'h00},
        '{KIND_TICK,     6'd0,  15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_READ,     6'd63, 15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_READ,     6'd1,  15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_SET,      6'd2,  15'd0,     8'h00, 8'hff, 8'h00, 7'd0,  8'sd0,   0, 8'h00, 8'h00, 8'h00},
        '{KIND_READ,     6'd2,  15'd0,     8'h00, 8'h00, 8'h00, 7'd0,  8'sd0,   1, 8'h00, 8'hff, 8'h00}
    };

    // Main sequence: reset, directed rows, then random phases under several
    // register settings, the extremes among them.
    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        kind        = '0;
        led         = '0;
        duration    = '0;
        red         = '0;
        green       = '0;
        blue        = '0;
        range_count = '0;
        jump        = '0;
        cfg_write   = 1'b0;
        cfg_index   = 1'b0;
        cfg_data    = '0;
        mismatch_cnt = 0;
        stall_cycles = 0;
        steady       = 1'b0;
        active_count    = LEDS;
        clear_on_report = 1'b0;
        for (int i = 0; i < LEDS; i++)
        begin
            span_q[i] = 0;
            for (int ch = 0; ch < 3; ch++)
            begin
                color_q[i][ch]  = '0;
                target_q[i][ch] = '0;
                step_q[i][ch]   = 0;
                acc_q[i][ch]    = 0;
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_command(directed_rows[r]);
        random_phase(32);
        drain_engine();

        // Full LED count with accumulator clearing on report.
        write_register(CFG_LED_COUNT, 7'd64);
        write_register(CFG_REPORT, 1'b1);
        random_phase(32);
        drain_engine();

        // Partial LED count: many commands now fall outside the range.
        write_register(CFG_LED_COUNT, 7'd17);
        write_register(CFG_REPORT, 1'b0);
        random_phase(30);
        drain_engine();

        // No LEDs at all: everything is dropped.
        write_register(CFG_LED_COUNT, 7'd0);
        random_phase(10);
        drain_engine();

        // Single LED with clearing back on.
        write_register(CFG_LED_COUNT, 7'd1);
        write_register(CFG_REPORT, 1'b1);
        random_phase(23);
        drain_engine();

        if (mismatch_cnt == 0 && pending_colors.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lbf_pkg.sv
hdl/lbf_ram.sv
hdl/lbf_fifo.sv
hdl/lbf_front.sv
hdl/lbf_back.sv
hdl/led_bresenham_fade_engine_top.sv
bench/tb_top.sv
